// ===== hdl/dts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the delimiter token splitter: request
// payloads, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int unsigned DEF_MAX_SEP_LEN = 8;
  localparam int unsigned SEP_LEN_W       = 4;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [SEP_LEN_W-1:0]  SEP_LEN_RST   = SEP_LEN_W'(1);
  localparam logic [CFG_DATA_W-1:0] SEP_BYTES_RST = CFG_DATA_W'(44);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEP_LEN   = 1'b0,
    CFG_SEP_BYTES = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       carries_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_done;
    logic       string_done;
    logic       run_last;
  } out_item_t;

endpackage

// ===== hdl/delimiter_token_splitter_top.sv =====
`timescale 1ns / 1ps
// The first result of an accepted request is registered in a result slot before it shows.
// Throughput: one request per cycle while each request yields at most one result and the
//   output is not stalled; a request that yields n results holds the output port for n results.
// Two result slots sit after the window logic, so input keeps flowing while one waits.
// Reset clears the window count, the token state and both result slots; the separator
//   resets to a single comma. Window bytes are not cleared.
// ----------------------------------------------------------------------------
// delimiter_token_splitter_top
// Splits a byte string into tokens at a configurable separator of up to
// MAX_SEP_LEN bytes, releasing each byte once it can no longer start a match.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_top
  import dts_pkg::*;
#(
  parameter int unsigned MAX_SEP_LEN = DEF_MAX_SEP_LEN
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_SEP_LEN + 1);
  localparam int unsigned NB_W  = $clog2(MAX_SEP_LEN + 2);

  typedef logic [MAX_SEP_LEN-1:0][7:0] win_t;
  typedef logic [MAX_SEP_LEN:0][7:0]   seq_t;

  typedef struct packed {
    logic            pre_e;
    logic [NB_W-1:0] nb;
    logic            td_last;
    logic            sd_last;
    logic            post_e;
    logic            post_f;
  } jctl_t;

  function automatic logic job_busy(input jctl_t j);
    return j.pre_e | j.post_e | j.post_f | (j.nb != '0);
  endfunction

  function automatic logic sep_match(input win_t v, input logic [CFG_DATA_W-1:0] sep,
                                     input logic [CNT_W-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      if (CNT_W'(i) < len && v[i] != sep[8*i +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [SEP_LEN_W-1:0]  sep_len_q;
  logic [CFG_DATA_W-1:0] sep_bytes_q;
  win_t                  win_q, win_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  started_q, started_d;
  jctl_t                 head_c_q, head_c_d, tail_c_q, tail_c_d;
  seq_t                  head_b_q, head_b_d, tail_b_q, tail_b_d;

  logic             accept, pop;
  logic [CNT_W-1:0] len, npop, shamt, cnt2;
  logic             match_old, case_a, started1, match2;
  seq_t             ext_v, shifted;
  win_t             neww;
  jctl_t            nj_c, hp_c;
  seq_t             nj_b, hp_b;
  logic [NB_W:0]    rem;

  assign in_stall_o = job_busy(tail_c_q);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_valid_o = job_busy(head_c_q);
  assign pop        = out_valid_o & ~out_stall_i;

  // Separator length clamped to 1..MAX_SEP_LEN.
  always_comb begin
    if (sep_len_q == '0) begin
      len = CNT_W'(1);
    end else if (sep_len_q > SEP_LEN_W'(MAX_SEP_LEN)) begin
      len = CNT_W'(MAX_SEP_LEN);
    end else begin
      len = CNT_W'(sep_len_q);
    end
  end

  // Window logic: held bytes followed by the new byte form one sequence.
  always_comb begin
    ext_v = {(MAX_SEP_LEN + 1){in_data_i.in_byte}};
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      if (CNT_W'(i) < cnt_q) begin
        ext_v[i] = win_q[i];
      end
    end
    match_old = (cnt_q == len) && sep_match(win_q, sep_bytes_q, len);
    case_a    = in_data_i.carries_byte && !started_q && match_old;
    npop      = (cnt_q >= len) ? cnt_q - len + CNT_W'(1) : '0;
    shamt     = case_a ? cnt_q : npop;
    shifted   = ext_v >> {shamt, 3'b000};
    neww      = shifted[MAX_SEP_LEN-1:0];
    started1  = started_q | (npop != '0);
    cnt2      = (npop != '0) ? len : cnt_q + CNT_W'(1);
    match2    = started1 && (cnt2 == len) && sep_match(neww, sep_bytes_q, len);
  end

  // Build the result job and the next window state for this request.
  always_comb begin
    nj_c      = '0;
    nj_b      = ext_v;
    cnt_d     = cnt_q;
    started_d = started_q;
    win_d     = win_q;
    if (in_data_i.carries_byte) begin
      win_d = neww;
      if (case_a) begin
        nj_c.pre_e   = 1'b1;
        nj_c.nb      = in_data_i.end_of_string ? NB_W'(1) : '0;
        nj_c.td_last = in_data_i.end_of_string;
        nj_c.sd_last = in_data_i.end_of_string;
        nj_b         = shifted;
        cnt_d        = CNT_W'(1);
        started_d    = 1'b0;
      end else if (match2) begin
        nj_c.nb      = NB_W'(npop);
        nj_c.td_last = 1'b1;
        nj_c.post_e  = (npop == '0);
        nj_c.post_f  = in_data_i.end_of_string;
        cnt_d        = '0;
        started_d    = 1'b0;
      end else begin
        nj_c.nb      = in_data_i.end_of_string ? NB_W'(cnt_q) + NB_W'(1) : NB_W'(npop);
        nj_c.td_last = in_data_i.end_of_string;
        nj_c.sd_last = in_data_i.end_of_string;
        cnt_d        = cnt2;
        started_d    = started1;
      end
    end else if (in_data_i.end_of_string) begin
      nj_c.nb      = NB_W'(cnt_q);
      nj_c.td_last = 1'b1;
      nj_c.sd_last = 1'b1;
      nj_c.post_f  = (cnt_q == '0);
    end
    if (in_data_i.end_of_string) begin
      cnt_d     = '0;
      started_d = 1'b0;
    end
  end

  // Current result from the head slot.
  always_comb begin
    out_data_o = '0;
    if (head_c_q.pre_e) begin
      out_data_o.token_done = 1'b1;
    end else if (head_c_q.nb != '0) begin
      out_data_o.out_byte    = head_b_q[0];
      out_data_o.byte_valid  = 1'b1;
      out_data_o.token_done  = (head_c_q.nb == NB_W'(1)) && head_c_q.td_last;
      out_data_o.string_done = (head_c_q.nb == NB_W'(1)) && head_c_q.sd_last;
    end else if (head_c_q.post_e) begin
      out_data_o.token_done = 1'b1;
    end else if (head_c_q.post_f) begin
      out_data_o.token_done  = 1'b1;
      out_data_o.string_done = 1'b1;
    end
    rem = {1'b0, head_c_q.nb} + (NB_W + 1)'(head_c_q.pre_e)
        + (NB_W + 1)'(head_c_q.post_e) + (NB_W + 1)'(head_c_q.post_f);
    out_data_o.run_last = (rem == (NB_W + 1)'(1));
  end

  // Advance the head slot, promote the tail, then place the new job.
  always_comb begin
    hp_c = head_c_q;
    hp_b = head_b_q;
    if (pop) begin
      if (head_c_q.pre_e) begin
        hp_c.pre_e = 1'b0;
      end else if (head_c_q.nb != '0) begin
        hp_c.nb = head_c_q.nb - NB_W'(1);
        hp_b    = head_b_q >> 8;
      end else if (head_c_q.post_e) begin
        hp_c.post_e = 1'b0;
      end else begin
        hp_c.post_f = 1'b0;
      end
    end
    head_c_d = hp_c;
    head_b_d = hp_b;
    tail_c_d = tail_c_q;
    tail_b_d = tail_b_q;
    if (!job_busy(hp_c) && job_busy(tail_c_q)) begin
      head_c_d = tail_c_q;
      head_b_d = tail_b_q;
      tail_c_d = '0;
    end
    if (accept && job_busy(nj_c)) begin
      if (!job_busy(head_c_d)) begin
        head_c_d = nj_c;
        head_b_d = nj_b;
      end else begin
        tail_c_d = nj_c;
        tail_b_d = nj_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_len_q   <= SEP_LEN_RST;
      sep_bytes_q <= SEP_BYTES_RST;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      head_c_q    <= '0;
      tail_c_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEP_LEN:   sep_len_q   <= cfg_data_i[SEP_LEN_W-1:0];
          CFG_SEP_BYTES: sep_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q     <= cnt_d;
        started_q <= started_d;
      end
      head_c_q <= head_c_d;
      tail_c_q <= tail_c_d;
    end
  end

  // Payload storage: no reset.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.carries_byte) begin
      win_q <= win_d;
    end
    head_b_q <= head_b_d;
    tail_b_q <= tail_b_d;
  end

endmodule

// ===== hdl/dts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks for the delimiter token splitter, bound to the top level.
// ----------------------------------------------------------------------------
module dts_checker
  import dts_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Input stalls only while results are queued.
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Every result carries a byte or ends a token.
  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid || out_data_o.token_done))
    else $error("result with neither byte nor token end");

  // A result without a byte shows a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |-> (out_data_o.out_byte == 8'h00))
    else $error("nonzero byte on a result without a byte");

  // The string end closes a token and is the last result of its request.
  a_string_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.string_done) |->
      (out_data_o.token_done && out_data_o.run_last))
    else $error("string end not a final token end");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind delimiter_token_splitter_top dts_checker u_dts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/delimiter_token_splitter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_token_splitter_top_test
// Feeds byte strings to the splitter under a range of separator settings and
// compares every token piece it returns with an in-bench split predictor.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_top_test;
  import dts_pkg::*;

  localparam int unsigned WIN_DEPTH = DEF_MAX_SEP_LEN;
  localparam int unsigned GAP_PCT   = 16;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  in_item_t              req_data  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  out_item_t             res_data;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = CFG_SEP_LEN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // split predictor state
  logic [SEP_LEN_W-1:0]  sep_len_m   = SEP_LEN_RST;
  logic [CFG_DATA_W-1:0] sep_bytes_m = SEP_BYTES_RST;
  logic [7:0]            win_m [WIN_DEPTH];
  int unsigned           win_cnt_m    = 0;
  bit                    token_open_m = 1'b0;

  out_item_t   token_pieces_q [$];
  out_item_t   want_piece;
  int unsigned piece_errors   = 0;
  int unsigned pieces_checked = 0;
  int unsigned items_sent     = 0;
  int unsigned strings_sent   = 0;
  bit          gaps_on        = 1'b1;

  delimiter_token_splitter_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout with %0d token pieces outstanding", token_pieces_q.size());
    $display("delimiter_token_splitter_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned eff_sep_len();
    if (sep_len_m == '0) return 1;
    if (sep_len_m > WIN_DEPTH) return WIN_DEPTH;
    return int'(sep_len_m);
  endfunction

  function automatic bit window_is_sep(input int unsigned len);
    if (win_cnt_m != len) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (win_m[i] != sep_bytes_m[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] take_oldest();
    logic [7:0] b;
    b = win_m[0];
    for (int unsigned i = 1; i < win_cnt_m; i++) win_m[i-1] = win_m[i];
    if (win_cnt_m > 0) win_cnt_m--;
    return b;
  endfunction

  function automatic out_item_t make_piece(input logic [7:0] b, input bit bv, input bit td,
                                           input bit sd);
    out_item_t p;
    p.out_byte    = b;
    p.byte_valid  = bv;
    p.token_done  = td;
    p.string_done = sd;
    p.run_last    = 1'b0;
    return p;
  endfunction

  task automatic split_request(input in_item_t req);
    out_item_t   outs [16];
    int unsigned n;
    int unsigned len;
    bit          released;
    bit          last;
    n        = 0;
    len      = eff_sep_len();
    released = 1'b0;
    if (req.carries_byte) begin
      if (!token_open_m && window_is_sep(len)) begin
        // held match at token start turns into an empty token
        outs[n] = make_piece(8'h00, 1'b0, 1'b1, 1'b0);
        n++;
        win_cnt_m = 0;
      end else begin
        while (win_cnt_m >= len && win_cnt_m > 0) begin
          outs[n] = make_piece(take_oldest(), 1'b1, 1'b0, 1'b0);
          n++;
          token_open_m = 1'b1;
          released     = 1'b1;
        end
      end
      if (win_cnt_m < WIN_DEPTH) begin
        win_m[win_cnt_m] = req.in_byte;
        win_cnt_m++;
      end
      if (token_open_m && window_is_sep(len)) begin
        if (released) outs[n-1].token_done = 1'b1;
        else begin
          outs[n] = make_piece(8'h00, 1'b0, 1'b1, 1'b0);
          n++;
        end
        win_cnt_m    = 0;
        token_open_m = 1'b0;
      end
    end
    if (req.end_of_string) begin
      if (win_cnt_m == 0) begin
        outs[n] = make_piece(8'h00, 1'b0, 1'b1, 1'b1);
        n++;
      end else begin
        while (win_cnt_m > 0) begin
          last    = (win_cnt_m == 1);
          outs[n] = make_piece(take_oldest(), 1'b1, last, last);
          n++;
        end
      end
      win_cnt_m    = 0;
      token_open_m = 1'b0;
    end
    if (n > 0) outs[n-1].run_last = 1'b1;
    for (int unsigned i = 0; i < n; i++) token_pieces_q.push_back(outs[i]);
  endtask

  // ----------------------------------------------------------------- checking
  task automatic report_bad(input string what, input logic [7:0] got, input logic [7:0] want);
    piece_errors++;
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) begin
      if (token_pieces_q.size() == 0) begin
        report_bad("unexpected token piece", res_data.out_byte, 8'h00);
      end else begin
        want_piece = token_pieces_q.pop_front();
        pieces_checked++;
        if (res_data.out_byte !== want_piece.out_byte)
          report_bad("out_byte", res_data.out_byte, want_piece.out_byte);
        if (res_data.byte_valid !== want_piece.byte_valid)
          report_bad("byte_valid", 8'(res_data.byte_valid), 8'(want_piece.byte_valid));
        if (res_data.token_done !== want_piece.token_done)
          report_bad("token_done", 8'(res_data.token_done), 8'(want_piece.token_done));
        if (res_data.string_done !== want_piece.string_done)
          report_bad("string_done", 8'(res_data.string_done), 8'(want_piece.string_done));
        if (res_data.run_last !== want_piece.run_last)
          report_bad("run_last", 8'(res_data.run_last), 8'(want_piece.run_last));
      end
    end
  end

  always @(posedge clk) begin
    res_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  // ----------------------------------------------------------------- stimulus
  task automatic send_req(input logic [7:0] b, input bit has_byte, input bit ends);
    in_item_t req;
    req.in_byte       = b;
    req.carries_byte  = has_byte;
    req.end_of_string = ends;
    if (gaps_on && $urandom_range(99) < GAP_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
    split_request(req);
    if (has_byte || ends) items_sent++;
    if (ends) strings_sent++;
  endtask

  // Send a byte run; when closing, either tag the last byte or add a pure end marker.
  task automatic send_run(input logic [7:0] text [$], input bit close, input bit pure_end,
                          input int unsigned noise_pct);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(99) < noise_pct) send_req(8'($urandom), 1'b0, 1'b0);
      send_req(text[i], 1'b1, close && !pure_end && i == text.size() - 1);
    end
    if (close && (pure_end || text.size() == 0)) send_req(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_text(input string s, input bit close, input bit pure_end);
    logic [7:0] text [$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_run(text, close, pure_end, 0);
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic drain();
    req_valid <= 1'b0;
    while (token_pieces_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEP_LEN) sep_len_m = value[SEP_LEN_W-1:0];
    else sep_bytes_m = value;
  endtask

  task automatic set_separator(input logic [SEP_LEN_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] sep);
    drain();
    write_reg(CFG_SEP_LEN, CFG_DATA_W'(len));
    write_reg(CFG_SEP_BYTES, sep);
  endtask

  function automatic logic [7:0] pick_sym();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h61 + 8'($urandom_range(1));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly separator fragments and near misses so matches and held windows are common.
  task automatic random_string(input bit close);
    logic [7:0]  text [$];
    int unsigned len;
    int unsigned cut;
    len = eff_sep_len();
    repeat ($urandom_range(6)) begin
      case ($urandom_range(2))
        0: for (int unsigned i = 0; i < len; i++) text.push_back(sep_bytes_m[8*i +: 8]);
        1: begin
          cut = (len > 1) ? $urandom_range(len - 1, 1) : 1;
          for (int unsigned i = 0; i < cut; i++) text.push_back(sep_bytes_m[8*i +: 8]);
        end
        default: repeat ($urandom_range(3, 1)) text.push_back(pick_sym());
      endcase
    end
    send_run(text, close, 1'($urandom_range(1)), 5);
  endtask

  function automatic logic [SEP_LEN_W-1:0] phase_len(input int p);
    case (p)
      0:       return SEP_LEN_W'(1);
      1:       return SEP_LEN_W'(8);
      2:       return SEP_LEN_W'(0);
      3:       return SEP_LEN_W'(15);
      default: return SEP_LEN_W'($urandom_range(7, 2));
    endcase
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_default_comma();
    send_text("a,b", 1'b1, 1'b0);
    send_text("", 1'b1, 1'b1);
    send_text("a,", 1'b1, 1'b1);
    send_req(8'h5a, 1'b0, 1'b0);
  endtask

  task automatic test_multi_byte_sep();
    set_separator(SEP_LEN_W'(3), 64'h7a7978);
    send_text("xyz", 1'b1, 1'b0);
    send_text("xyz", 1'b1, 1'b1);
    send_text("xyzq", 1'b1, 1'b0);
  endtask

  task automatic test_len_extremes();
    set_separator(SEP_LEN_W'(0), '0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b1);
    set_separator(SEP_LEN_W'(15), '1);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_len_lowered();
    set_separator(SEP_LEN_W'(8), {$urandom, $urandom});
    send_text("abcd", 1'b0, 1'b0);
    drain();
    write_reg(CFG_SEP_LEN, CFG_DATA_W'(2));
    send_text("e", 1'b1, 1'b0);
  endtask

  task automatic test_random_strings();
    logic [CFG_DATA_W-1:0] sep;
    int unsigned           goal;
    for (int p = 0; p < 5; p++) begin
      for (int b = 0; b < 8; b++) sep[8*b +: 8] = pick_sym();
      set_separator(phase_len(p), sep);
      goal = items_sent + 6;
      while (items_sent < goal) random_string(1'b1);
      // half the time, leave a string open so the next setting lands on held bytes
      if ($urandom_range(1)) random_string(1'b0);
    end
  endtask

  task automatic test_back_to_back();
    int unsigned goal;
    set_separator(SEP_LEN_W'(3), {$urandom, $urandom});
    gaps_on = 1'b0;
    goal    = items_sent + 20;
    while (items_sent < goal) random_string(1'b1);
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_comma();
    test_multi_byte_sep();
    test_len_extremes();
    test_len_lowered();
    test_random_strings();
    test_back_to_back();
    drain();
    $display("split %0d strings from %0d requests over several separator settings",
             strings_sent, items_sent);
    $display("%0d token pieces checked, %0d mismatches", pieces_checked, piece_errors);
    if (piece_errors == 0 && token_pieces_q.size() == 0) begin
      $display("delimiter_token_splitter_top test passed");
    end else begin
      $display("delimiter_token_splitter_top test failed");
    end
    $finish;
  end

endmodule
